// File: design/script_lexer_tokenizer_assert.svh
// assertion macros for the script lexer
`ifndef SCRIPT_LEXER_TOKENIZER_ASSERT_SVH
`define SCRIPT_LEXER_TOKENIZER_ASSERT_SVH

// property checked at every clock edge outside reset
`define SLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition followed by a consequence in the next cycle
`define SLT_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: design/slt_pkg.sv
// shared types, constants and keyword lookup for the script lexer
package slt_pkg;

  localparam int OFFSET_W = 32;
  localparam int LINE_W   = 24;
  localparam int LENGTH_W = 16;
  localparam int KIND_W   = 6;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [LENGTH_W-1:0] LEN_MAX  = {LENGTH_W{1'b1}};
  localparam logic [LINE_W-1:0]   LINE_MAX = {LINE_W{1'b1}};

  localparam logic [KIND_W-1:0] K_LPAREN   = 6'd0;
  localparam logic [KIND_W-1:0] K_RPAREN   = 6'd1;
  localparam logic [KIND_W-1:0] K_LBRACE   = 6'd2;
  localparam logic [KIND_W-1:0] K_RBRACE   = 6'd3;
  localparam logic [KIND_W-1:0] K_SEMI     = 6'd4;
  localparam logic [KIND_W-1:0] K_COMMA    = 6'd5;
  localparam logic [KIND_W-1:0] K_DOT      = 6'd6;
  localparam logic [KIND_W-1:0] K_MINUS    = 6'd7;
  localparam logic [KIND_W-1:0] K_MINUS2   = 6'd8;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd9;
  localparam logic [KIND_W-1:0] K_PLUS2    = 6'd10;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd11;
  localparam logic [KIND_W-1:0] K_PERCENT  = 6'd12;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd13;
  localparam logic [KIND_W-1:0] K_STAR2    = 6'd14;
  localparam logic [KIND_W-1:0] K_BANG     = 6'd15;
  localparam logic [KIND_W-1:0] K_BANG_EQ  = 6'd16;
  localparam logic [KIND_W-1:0] K_EQ       = 6'd17;
  localparam logic [KIND_W-1:0] K_EQ_EQ    = 6'd18;
  localparam logic [KIND_W-1:0] K_GT       = 6'd19;
  localparam logic [KIND_W-1:0] K_GT_EQ    = 6'd20;
  localparam logic [KIND_W-1:0] K_LT       = 6'd21;
  localparam logic [KIND_W-1:0] K_LT_EQ    = 6'd22;
  localparam logic [KIND_W-1:0] K_IDENT    = 6'd23;
  localparam logic [KIND_W-1:0] K_STRING   = 6'd24;
  localparam logic [KIND_W-1:0] K_NUMBER   = 6'd25;
  localparam logic [KIND_W-1:0] K_AND      = 6'd26;
  localparam logic [KIND_W-1:0] K_CLASS    = 6'd27;
  localparam logic [KIND_W-1:0] K_ELSE     = 6'd28;
  localparam logic [KIND_W-1:0] K_FALSE    = 6'd29;
  localparam logic [KIND_W-1:0] K_FOR      = 6'd30;
  localparam logic [KIND_W-1:0] K_FUN      = 6'd31;
  localparam logic [KIND_W-1:0] K_IF       = 6'd32;
  localparam logic [KIND_W-1:0] K_NIL      = 6'd33;
  localparam logic [KIND_W-1:0] K_OR       = 6'd34;
  localparam logic [KIND_W-1:0] K_PRINT    = 6'd35;
  localparam logic [KIND_W-1:0] K_RETURN   = 6'd36;
  localparam logic [KIND_W-1:0] K_SELF     = 6'd37;
  localparam logic [KIND_W-1:0] K_SUPER    = 6'd38;
  localparam logic [KIND_W-1:0] K_TRUE     = 6'd39;
  localparam logic [KIND_W-1:0] K_VAR      = 6'd40;
  localparam logic [KIND_W-1:0] K_WHILE    = 6'd41;
  localparam logic [KIND_W-1:0] K_ERR_STR  = 6'd42;
  localparam logic [KIND_W-1:0] K_ERR_CHAR = 6'd43;
  localparam logic [KIND_W-1:0] K_EOF      = 6'd44;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] start;
    logic [LENGTH_W-1:0] len;
    logic [LINE_W-1:0]   line;
    logic                last;
  } tok_t;

  typedef struct packed {
    logic [1:0]     n;
    tok_t [2:0]     tok;
  } push_t;

  // first source byte sits in the low byte of the prefix
  function automatic logic kw_hit(input logic [47:0] pfx, input logic [LENGTH_W-1:0] len,
                                  input logic [47:0] word, input int n);
    logic hit;
    hit = (len == LENGTH_W'(n));
    for (int j = 0; j < 6; j++) begin
      if (j < n && pfx[8*j +: 8] != word[8*(n-1-j) +: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic [KIND_W-1:0] ident_kind(input logic [47:0] pfx,
                                                   input logic [LENGTH_W-1:0] len);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if (kw_hit(pfx, len, 48'("and"), 3))    k = K_AND;
    if (kw_hit(pfx, len, 48'("class"), 5))  k = K_CLASS;
    if (kw_hit(pfx, len, 48'("else"), 4))   k = K_ELSE;
    if (kw_hit(pfx, len, 48'("false"), 5))  k = K_FALSE;
    if (kw_hit(pfx, len, 48'("for"), 3))    k = K_FOR;
    if (kw_hit(pfx, len, 48'("fun"), 3))    k = K_FUN;
    if (kw_hit(pfx, len, 48'("if"), 2))     k = K_IF;
    if (kw_hit(pfx, len, 48'("nil"), 3))    k = K_NIL;
    if (kw_hit(pfx, len, 48'("or"), 2))     k = K_OR;
    if (kw_hit(pfx, len, 48'("print"), 5))  k = K_PRINT;
    if (kw_hit(pfx, len, 48'("return"), 6)) k = K_RETURN;
    if (kw_hit(pfx, len, 48'("self"), 4))   k = K_SELF;
    if (kw_hit(pfx, len, 48'("super"), 5))  k = K_SUPER;
    if (kw_hit(pfx, len, 48'("true"), 4))   k = K_TRUE;
    if (kw_hit(pfx, len, 48'("var"), 3))    k = K_VAR;
    if (kw_hit(pfx, len, 48'("while"), 5))  k = K_WHILE;
    return k;
  endfunction

endpackage

// File: design/slt_front.sv
// scanner front: takes source bytes and produces up to three tokens per byte
module slt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    source_byte_i,
  input  logic          end_of_source_i,
  input  logic          space_ok_i,
  output slt_pkg::push_t push_o
);
  import slt_pkg::*;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_SLASH   = 9'b000000010,
    PH_COMMENT = 9'b000000100,
    PH_OP      = 9'b000001000,
    PH_INT     = 9'b000010000,
    PH_DOT     = 9'b000100000,
    PH_FRAC    = 9'b001000000,
    PH_IDENT   = 9'b010000000,
    PH_STRING  = 9'b100000000
  } phase_e;

  phase_e              ph_q, ph_d;
  logic [OFFSET_W-1:0] tb_q, tb_d, pos_q, pos_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic [LENGTH_W-1:0] len_q, len_d;
  logic [47:0]         pfx_q, pfx_d;
  logic [7:0]          held_q, held_d;

  logic       acc, restart, fl;
  logic [2:0] v;
  tok_t [2:0] a;
  logic [7:0] c;
  logic [7:0] op_second;
  logic [KIND_W-1:0] op_single, op_dbl;
  logic [1:0] idx;
  tok_t [2:0] e;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic [LENGTH_W-1:0] sat_add(input logic [LENGTH_W-1:0] l,
                                                 input logic [1:0] inc);
    logic [LENGTH_W:0] s;
    s = {1'b0, l} + {{(LENGTH_W-1){1'b0}}, inc};
    return s[LENGTH_W] ? LEN_MAX : s[LENGTH_W-1:0];
  endfunction

  function automatic tok_t mk(input logic [KIND_W-1:0] k, input logic [OFFSET_W-1:0] s,
                              input logic [LENGTH_W-1:0] l, input logic [LINE_W-1:0] ln);
    tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.line  = ln;
    t.last  = 1'b0;
    return t;
  endfunction

  assign in_ready_o = space_ok_i;
  assign acc = in_valid_i && in_ready_o;
  assign c   = source_byte_i;

  always_comb begin
    op_second = "=";
    op_single = K_LT;
    op_dbl    = K_LT_EQ;
    case (held_q)
      "-": begin op_second = "-"; op_single = K_MINUS; op_dbl = K_MINUS2; end
      "+": begin op_second = "+"; op_single = K_PLUS;  op_dbl = K_PLUS2;  end
      "*": begin op_second = "*"; op_single = K_STAR;  op_dbl = K_STAR2;  end
      "!": begin op_single = K_BANG; op_dbl = K_BANG_EQ; end
      "=": begin op_single = K_EQ;   op_dbl = K_EQ_EQ;   end
      ">": begin op_single = K_GT;   op_dbl = K_GT_EQ;   end
      default: ;
    endcase
  end

  always_comb begin
    ph_d = ph_q; tb_d = tb_q; pos_d = pos_q; line_d = line_q;
    len_d = len_q; pfx_d = pfx_q; held_d = held_q;
    v = '0;
    a = '0;
    restart = 1'b0;
    fl = 1'b0;
    if (acc) begin
      pos_d = pos_q + 1'b1;
      if (end_of_source_i) begin
        fl = (ph_q != PH_COMMENT);
      end else begin
        case (ph_q)
          PH_IDLE: restart = 1'b1;
          PH_SLASH: begin
            if (c == "/") ph_d = PH_COMMENT;
            else begin fl = 1'b1; restart = 1'b1; end
          end
          PH_COMMENT: begin
            if (c == "\n") begin
              if (line_q != LINE_MAX) line_d = line_q + 1'b1;
              ph_d = PH_IDLE;
            end
          end
          PH_OP: begin
            if (c == op_second) begin
              v[2] = 1'b1;
              a[2] = mk(op_dbl, tb_q, LENGTH_W'(2), line_q);
              ph_d = PH_IDLE;
            end else begin fl = 1'b1; restart = 1'b1; end
          end
          PH_INT: begin
            if (is_digit(c)) len_d = sat_add(len_q, 2'd1);
            else if (c == ".") ph_d = PH_DOT;
            else begin fl = 1'b1; restart = 1'b1; end
          end
          PH_DOT: begin
            if (is_digit(c)) begin
              len_d = sat_add(len_q, 2'd2);
              ph_d = PH_FRAC;
            end else begin fl = 1'b1; restart = 1'b1; end
          end
          PH_FRAC: begin
            if (is_digit(c)) len_d = sat_add(len_q, 2'd1);
            else begin fl = 1'b1; restart = 1'b1; end
          end
          PH_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              // only the first six bytes matter for keywords
              for (int j = 0; j < 6; j++) begin
                if (len_q == LENGTH_W'(j)) pfx_d[8*j +: 8] = c;
              end
              len_d = sat_add(len_q, 2'd1);
            end else begin fl = 1'b1; restart = 1'b1; end
          end
          PH_STRING: begin
            len_d = sat_add(len_q, 2'd1);
            if (c == "\n" && line_q != LINE_MAX) line_d = line_q + 1'b1;
            if (c == "\"") begin
              v[2] = 1'b1;
              a[2] = mk(K_STRING, tb_q, len_d, line_q);
              ph_d = PH_IDLE;
            end
          end
          default: ;
        endcase
      end

      if (fl) begin
        ph_d = PH_IDLE;
        case (ph_q)
          PH_SLASH: begin v[0] = 1'b1; a[0] = mk(K_SLASH, tb_q, LENGTH_W'(1), line_q); end
          PH_OP:    begin v[0] = 1'b1; a[0] = mk(op_single, tb_q, LENGTH_W'(1), line_q); end
          PH_INT, PH_FRAC: begin
            v[0] = 1'b1; a[0] = mk(K_NUMBER, tb_q, len_q, line_q);
          end
          PH_DOT: begin
            v[0] = 1'b1; a[0] = mk(K_NUMBER, tb_q, len_q, line_q);
            v[1] = 1'b1; a[1] = mk(K_DOT, pos_q - 1'b1, LENGTH_W'(1), line_q);
          end
          PH_IDENT: begin
            v[0] = 1'b1; a[0] = mk(ident_kind(pfx_q, len_q), tb_q, len_q, line_q);
          end
          PH_STRING: begin v[0] = 1'b1; a[0] = mk(K_ERR_STR, tb_q, len_q, line_q); end
          default: ;
        endcase
      end

      if (restart) begin
        ph_d = PH_IDLE;
        if (c == " " || c == "\r" || c == "\t") begin
        end else if (c == "\n") begin
          if (line_q != LINE_MAX) line_d = line_q + 1'b1;
        end else if (is_digit(c)) begin
          ph_d = PH_INT; tb_d = pos_q; len_d = LENGTH_W'(1);
        end else if (is_alpha(c)) begin
          ph_d = PH_IDENT; tb_d = pos_q; len_d = LENGTH_W'(1); pfx_d = {40'd0, c};
        end else begin
          v[2] = 1'b1;
          a[2] = mk(K_ERR_CHAR, pos_q, LENGTH_W'(1), line_q);
          case (c)
            "(": a[2].kind = K_LPAREN;
            ")": a[2].kind = K_RPAREN;
            "{": a[2].kind = K_LBRACE;
            "}": a[2].kind = K_RBRACE;
            ";": a[2].kind = K_SEMI;
            ",": a[2].kind = K_COMMA;
            ".": a[2].kind = K_DOT;
            "%": a[2].kind = K_PERCENT;
            "/": begin v[2] = 1'b0; ph_d = PH_SLASH; tb_d = pos_q; end
            "-", "+", "*", "!", "=", ">", "<": begin
              v[2] = 1'b0; ph_d = PH_OP; held_d = c; tb_d = pos_q;
            end
            "\"": begin v[2] = 1'b0; ph_d = PH_STRING; tb_d = pos_q; len_d = LENGTH_W'(1); end
            default: ;
          endcase
        end
      end

      if (end_of_source_i) begin
        v[2] = 1'b1;
        a[2] = mk(K_EOF, pos_q, '0, line_q);
        ph_d = PH_IDLE; tb_d = '0; pos_d = '0; line_d = LINE_W'(1);
        len_d = '0; pfx_d = '0; held_d = '0;
      end
    end
  end

  // pack the tokens into the low slots, mark the final one
  always_comb begin
    e = '0;
    idx = 2'd0;
    for (int k = 0; k < 3; k++) begin
      if (v[k]) begin
        e[idx] = a[k];
        idx = idx + 2'd1;
      end
    end
    if (idx != 2'd0) e[idx - 2'd1].last = 1'b1;
    push_o.n   = idx;
    push_o.tok = e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      tb_q   <= '0;
      pos_q  <= '0;
      line_q <= LINE_W'(1);
      len_q  <= '0;
      pfx_q  <= '0;
      held_q <= '0;
    end else begin
      ph_q   <= ph_d;
      tb_q   <= tb_d;
      pos_q  <= pos_d;
      line_q <= line_d;
      len_q  <= len_d;
      pfx_q  <= pfx_d;
      held_q <= held_d;
    end
  end

endmodule

// File: design/slt_queue.sv
// token queue: up to three pushes and one pop per cycle
module slt_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slt_pkg::push_t         push_i,
  output logic                   space_ok_o,
  input  logic                   pop_i,
  output logic                   nonempty_o,
  output slt_pkg::tok_t          head_o,
  output logic [slt_pkg::QCNT_W-1:0] count_o
);
  import slt_pkg::*;

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;

  assign nonempty_o = (cnt_q != '0);
  assign pop        = pop_i && nonempty_o;
  assign space_ok_o = (cnt_q <= QCNT_W'(QDEPTH - 3));
  assign head_o     = mem_q[rd_q];
  assign count_o    = cnt_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_i.n) mem_q[wr_q + QPTR_W'(k)] <= push_i.tok[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(push_i.n);
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i.n) - QCNT_W'(pop);
    end
  end

endmodule

// File: design/slt_back.sv
// output stage: moves tokens from the queue into the result register
module slt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          nonempty_i,
  input  slt_pkg::tok_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output slt_pkg::tok_t out_o
);
  import slt_pkg::*;

  logic valid_q;
  tok_t tok_q;

  assign pop_o       = nonempty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) tok_q <= head_i;
  end

endmodule

// File: design/script_lexer_tokenizer.sv
// a completed token is written into the token queue, then moved into the result register
// throughput: one byte per cycle; each byte may queue up to three tokens
// output drains one token per cycle while out_ready_i is high; input stalls
// only while the eight-entry token queue lacks room for three more
// reset is asynchronous active low and clears scanner state and queue
`include "script_lexer_tokenizer_assert.svh"
module script_lexer_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [31:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [23:0] line_number_o,
  output logic        last_of_run_o
);
  import slt_pkg::*;

  push_t             push;
  logic              space_ok, pop, nonempty;
  tok_t              head, tok;
  logic [QCNT_W-1:0] count;

  slt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .source_byte_i, .end_of_source_i,
    .space_ok_i(space_ok), .push_o(push)
  );

  slt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .space_ok_o(space_ok), .pop_i(pop),
    .nonempty_o(nonempty), .head_o(head), .count_o(count)
  );

  slt_back u_back (
    .clk_i, .rst_ni, .nonempty_i(nonempty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_o(tok)
  );

  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign line_number_o  = tok.line;
  assign last_of_run_o  = tok.last;

  `SLT_ASSERT(a_queue_bound, count <= QCNT_W'(QDEPTH), "token queue overflow")
  `SLT_ASSERT(a_no_push_idle, (push.n == 2'd0) || (in_valid_i && in_ready_o),
              "tokens queued without a transfer")
  `SLT_ASSERT(a_eos_emits, !(in_valid_i && in_ready_o && end_of_source_i) || push.n != 2'd0,
              "end of source queued no token")
  `SLT_ASSERT_NEXT(a_pop_fills, pop, out_valid_o, "popped token not presented")

endmodule
